### src/rhhs_pkg.sv
package rhhs_pkg;

  localparam int KEY_W   = 64;
  localparam int DIST_W  = 4;
  localparam int CNT_W   = 11;
  localparam int LIMIT_W = 10;

  localparam logic [LIMIT_W-1:0] FILL_LIMIT_RST = 10'd921;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  localparam logic [1:0] ST_ABSENT   = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic       clear;
    logic       load_key;
    logic       hash_step;
    logic       load_home;
    logic       advance;
    logic       swap;
    logic       wr;
    logic       save_start;
    logic       restore;
    logic       inc_count;
    logic       load_out;
    logic [1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic used;
    logic ge;
    logic match;
    logic adv_fail;
    logic swap_fail;
    logic action;
    logic at_limit;
    logic out_busy;
  } stat_t;

endpackage

### src/rhhs_if.sv
interface rhhs_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [rhhs_pkg::KEY_W-1:0] key;
  modport source (output valid, action, key, input ready);
  modport sink (input valid, action, key, output ready);
endinterface

interface rhhs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [rhhs_pkg::CNT_W-1:0] key_count;
  modport source (output valid, status, key_count, input ready);
  modport sink (input valid, status, key_count, output ready);
endinterface

interface rhhs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rhhs_pkg::LIMIT_W-1:0] fill_limit;
  modport source (output valid, fill_limit, input ready);
  modport sink (input valid, fill_limit, output ready);
endinterface

### src/robin_hood_hash_set.sv
// Sequence: accept the word, hash one key byte per step, load the home slot, then read and
//   evaluate each probed slot; a new insert then walks its chain once for the check pass
//   and again for the write pass, and the result word is loaded last.
// Flow: one item at a time; a new word is taken only once the last result is loaded. The
//   result register lets the next word enter while a result waits.
// Reset: synchronous; clears the distance table one slot per cycle, all SLOTS slots
//   (1033 at the defaults), before the first word is taken; fill_limit resets to 921.
module robin_hood_hash_set #(
  parameter int LOG_SLOTS = 10,
  parameter int KEY_BYTES = 8
) (
  input logic        clk,
  input logic        rst,
  rhhs_req_if.sink   req,
  rhhs_rsp_if.source rsp,
  rhhs_cfg_if.sink   cfg
);

  rhhs_pkg::cmd_t  cmd;
  rhhs_pkg::stat_t st;

  // The register port always takes a write; the sender must write only while no word
  // is in flight, and the block itself does not enforce this.
  assign cfg.ready = 1'b1;

  // Controller: sequence the table clear, hashing, probing, the check pass, the write pass and the result load.
  rhhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: hash unit, probe position and distance, carried key, tables,
  // key count, fill limit and the result register.
  rhhs_dp #(
    .LOG_SLOTS(LOG_SLOTS),
    .KEY_BYTES(KEY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_action  (req.action),
    .in_key     (req.key),
    .cfg_we     (cfg.valid),
    .cfg_data   (cfg.fill_limit),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_count  (rsp.key_count)
  );

endmodule

### src/rhhs_ram.sv
module rhhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/rhhs_dp.sv
module rhhs_dp #(
  parameter int LOG_SLOTS = 10,
  parameter int KEY_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rhhs_pkg::cmd_t                cmd,
  output rhhs_pkg::stat_t               st,
  input  logic                          in_action,
  input  logic [rhhs_pkg::KEY_W-1:0]    in_key,
  input  logic                          cfg_we,
  input  logic [rhhs_pkg::LIMIT_W-1:0]  cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [rhhs_pkg::CNT_W-1:0]    out_count
);

  localparam int SLOTS  = (1 << LOG_SLOTS) - 1 + LOG_SLOTS;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int D_W    = rhhs_pkg::DIST_W + 1;
  localparam int BIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int ENT_W  = rhhs_pkg::DIST_W + 1;
  localparam logic [rhhs_pkg::KEY_W-1:0] KEY_MASK =
    {rhhs_pkg::KEY_W{1'b1}} >> (rhhs_pkg::KEY_W - 8 * KEY_BYTES);

  logic [rhhs_pkg::KEY_W-1:0]   kin;
  logic                         action;
  logic [rhhs_pkg::KEY_W-1:0]   carry;
  logic [31:0]                  h;
  logic [BIDX_W-1:0]            bidx;
  logic [ADDR_W-1:0]            pos;
  logic [D_W-1:0]               d;
  logic [ADDR_W-1:0]            sp;
  logic [D_W-1:0]               sd;
  logic [ADDR_W-1:0]            clr;
  logic [rhhs_pkg::CNT_W-1:0]   count;
  logic [rhhs_pkg::LIMIT_W-1:0] fill_limit;

  logic [ENT_W-1:0]           ent_rd;
  logic [ENT_W-1:0]           ent_wd;
  logic [ADDR_W-1:0]          ent_wa;
  logic                       ent_we;
  logic [rhhs_pkg::KEY_W-1:0] key_rd;
  logic [31:0]                mix;
  logic [ADDR_W:0]            pos_inc;
  logic [D_W-1:0]             d_inc;
  logic [D_W-1:0]             od_inc;

  assign mix     = h ^ {24'd0, kin[8*bidx +: 8]};
  assign pos_inc = {1'b0, pos} + 1'b1;
  assign d_inc   = d + 1'b1;
  assign od_inc  = {1'b0, ent_rd[rhhs_pkg::DIST_W-1:0]} + 1'b1;

  assign ent_we = cmd.clear | cmd.wr;
  assign ent_wa = cmd.clear ? clr : pos;
  assign ent_wd = cmd.clear ? '0 : {1'b1, d[rhhs_pkg::DIST_W-1:0]};

  rhhs_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_dist_ram (
    .clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(pos), .rdata(ent_rd)
  );

  rhhs_ram #(.WIDTH(rhhs_pkg::KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk(clk), .we(cmd.wr), .waddr(pos), .wdata(carry), .raddr(pos), .rdata(key_rd)
  );

  always_comb begin
    st.clr_last  = (clr == ADDR_W'(SLOTS - 1));
    st.hash_last = (bidx == BIDX_W'(KEY_BYTES - 1));
    st.used      = ent_rd[ENT_W-1];
    st.ge        = ({1'b0, ent_rd[rhhs_pkg::DIST_W-1:0]} >= d);
    st.match     = (key_rd == kin);
    st.adv_fail  = (pos_inc >= (ADDR_W+1)'(SLOTS)) || (d_inc >= D_W'(LOG_SLOTS));
    st.swap_fail = (pos_inc >= (ADDR_W+1)'(SLOTS)) || (od_inc >= D_W'(LOG_SLOTS));
    st.action    = action;
    st.at_limit  = (count >= {1'b0, fill_limit});
    st.out_busy  = out_valid & ~out_ready;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      count      <= '0;
      fill_limit <= rhhs_pkg::FILL_LIMIT_RST;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr <= clr + 1'b1;
      end
      if (cmd.inc_count) begin
        count <= count + 1'b1;
      end
      if (cfg_we) begin
        fill_limit <= cfg_data;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      kin    <= in_key & KEY_MASK;
      action <= in_action;
      h      <= rhhs_pkg::FNV_OFFSET;
      bidx   <= '0;
    end
    if (cmd.hash_step) begin
      h    <= mix * rhhs_pkg::FNV_PRIME;
      bidx <= bidx + 1'b1;
    end
    if (cmd.load_home) begin
      pos   <= ADDR_W'(h[LOG_SLOTS-1:0]);
      d     <= '0;
      carry <= kin;
    end
    if (cmd.save_start) begin
      sp <= pos;
      sd <= d;
    end
    if (cmd.restore) begin
      pos   <= sp;
      d     <= sd;
      carry <= kin;
    end else if (cmd.swap) begin
      pos   <= pos_inc[ADDR_W-1:0];
      d     <= od_inc;
      carry <= key_rd;
    end else if (cmd.advance) begin
      pos <= pos_inc[ADDR_W-1:0];
      d   <= d_inc;
    end
    if (cmd.load_out) begin
      out_status <= cmd.out_status;
      out_count  <= count;
    end
  end

endmodule

### src/rhhs_ctrl.sv
module rhhs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rhhs_pkg::stat_t st,
  output rhhs_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_HOME  = 4'd3;
  localparam logic [3:0] S_P_RD  = 4'd4;
  localparam logic [3:0] S_P_EV  = 4'd5;
  localparam logic [3:0] S_C_RD  = 4'd6;
  localparam logic [3:0] S_C_EV  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state, state_next;
  logic       commit, commit_next;
  logic [1:0] res, res_next;

  always_comb begin
    state_next  = state;
    commit_next = commit;
    res_next    = res;
    cmd         = '0;
    cmd.out_status = res;
    in_ready    = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_key = 1'b1;
          state_next   = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (st.hash_last) state_next = S_HOME;
      end
      S_HOME: begin
        cmd.load_home = 1'b1;
        state_next    = S_P_RD;
      end
      S_P_RD: state_next = S_P_EV;
      S_P_EV: begin
        if (st.used && st.ge) begin
          if (st.match) begin
            res_next   = rhhs_pkg::ST_PRESENT;
            state_next = S_DONE;
          end else if (st.adv_fail) begin
            res_next   = st.action ? rhhs_pkg::ST_FULL : rhhs_pkg::ST_ABSENT;
            state_next = S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_P_RD;
          end
        end else if (!st.action) begin
          res_next   = rhhs_pkg::ST_ABSENT;
          state_next = S_DONE;
        end else if (st.at_limit) begin
          res_next   = rhhs_pkg::ST_FULL;
          state_next = S_DONE;
        end else begin
          cmd.save_start = 1'b1;
          commit_next    = 1'b0;
          state_next     = S_C_RD;
        end
      end
      S_C_RD: state_next = S_C_EV;
      S_C_EV: begin
        if (!st.used) begin
          if (commit) begin
            cmd.wr        = 1'b1;
            cmd.inc_count = 1'b1;
            res_next      = rhhs_pkg::ST_INSERTED;
            state_next    = S_DONE;
          end else begin
            cmd.restore = 1'b1;
            commit_next = 1'b1;
            state_next  = S_C_RD;
          end
        end else if (st.ge) begin
          if (st.adv_fail) begin
            res_next   = rhhs_pkg::ST_FULL;
            state_next = S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_C_RD;
          end
        end else if (st.swap_fail) begin
          res_next   = rhhs_pkg::ST_FULL;
          state_next = S_DONE;
        end else begin
          cmd.wr     = commit;
          cmd.swap   = 1'b1;
          state_next = S_C_RD;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      commit <= 1'b0;
      res    <= rhhs_pkg::ST_ABSENT;
    end else begin
      state  <= state_next;
      commit <= commit_next;
      res    <= res_next;
    end
  end

  a_rd_then_ev: assert property (@(posedge clk) disable iff (rst)
    (state == S_P_RD) |=> (state == S_P_EV))
    else $error("probe read not followed by evaluation");
  a_wr_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> (commit && state == S_C_EV))
    else $error("table write outside commit pass");
  a_inc_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.inc_count |-> (!st.used && commit))
    else $error("count bumped without placing into an empty slot");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !st.out_busy)
    else $error("result overwritten while still waiting");

endmodule
